// ===== rtl/abt_pkg.sv =====
// ----------------------------------------------------------------------------
// Address blocklist table package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package abt_pkg;

	// Word layout
	localparam int CMD_W      = 2;
	localparam int KEY_HALF_W = 64;
	localparam int KEY_W      = 2 * KEY_HALF_W;
	localparam int KEY_BYTES  = KEY_W / 8;
	localparam int KEY_CHARS  = 15;
	localparam int STATUS_W   = 2;
	localparam int OUT_CNT_W  = 5;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic shift;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_done;
		logic need_shift;
		logic shift_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/abt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Address blocklist table controller
// Sequences load, table scan, removal shift and result write-back.
// ----------------------------------------------------------------------------
module abt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  abt_pkg::dp_stat_t stat,
	output abt_pkg::dp_cmd_t  cmd
);
	import abt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = stat.need_shift ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				if (stat.shift_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.load   = (state_q == S_IDLE) && s_axis_tvalid;
		cmd.scan   = (state_q == S_SCAN) && !stat.scan_done;
		cmd.shift  = (state_q == S_SHIFT) && !stat.shift_done;
		cmd.finish = (state_q == S_FINISH) && stat.out_free;
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== rtl/abt_datapath.sv =====
// ----------------------------------------------------------------------------
// Address blocklist table datapath
// Key store, scan pointer, compare, shift-down and result registers.
// ----------------------------------------------------------------------------
module abt_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [abt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [abt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  abt_pkg::dp_cmd_t                 cmd,
	output abt_pkg::dp_stat_t                stat
);
	import abt_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Key store
	logic [KEY_W-1:0] mem [MAX_ENTRIES];

	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    rd_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rp_q;
	logic [AW-1:0]       pend_idx_q;
	logic                pend_q;
	logic                found_q;
	logic                out_valid_q;
	logic                success_q;
	logic [STATUS_W-1:0] status_q;
	logic [OUT_CNT_W-1:0] entry_count_q;

	logic [KEY_W-1:0]    key_in;
	logic [KEY_W-1:0]    key_norm;
	logic                ended;
	logic [7:0]          key_byte;
	logic                hit;
	logic                scan_rd;
	logic                shift_rd;
	logic                rd_en;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_W-1:0]    wr_data;
	logic                add_ok;
	logic                table_full;
	logic                more;
	logic [CW-1:0]       count_d;
	logic                success_d;
	logic [STATUS_W-1:0] status_d;

	// Input word: command, key_high, key_low from bit 0 up
	assign key_in = {s_axis_tdata[CMD_W+KEY_HALF_W-1:CMD_W],
	                 s_axis_tdata[CMD_W+KEY_W-1:CMD_W+KEY_HALF_W]};

	// Key normalization: zero everything from the first NUL, cap at 15 chars
	always_comb begin
		ended    = 1'b0;
		key_norm = '0;
		key_byte = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_byte = key_in[KEY_W-1-8*i -: 8];
			if (i >= KEY_CHARS || key_byte == 8'd0) ended = 1'b1;
			key_norm[KEY_W-1-8*i -: 8] = ended ? 8'd0 : key_byte;
		end
	end

	// Scan / shift read and write selection
	always_comb begin
		more       = (rp_q < count_q);
		table_full = (count_q >= CW'(MAX_ENTRIES));
		hit        = cmd.scan && pend_q && (rd_q == key_q);
		scan_rd    = cmd.scan && !found_q && !hit && more;
		shift_rd   = cmd.shift && more;
		rd_en      = scan_rd || shift_rd;
		add_ok     = (cmd_q == CMD_ADD) && !table_full && !found_q;
		wr_en      = 1'b0;
		wr_addr    = pend_idx_q;
		wr_data    = rd_q;
		if (cmd.shift && pend_q) begin
			wr_en = 1'b1;
		end else if (cmd.finish && add_ok) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = key_q;
		end
	end

	// Result of the finished operation
	always_comb begin
		count_d   = count_q;
		success_d = 1'b0;
		status_d  = STAT_ABSENT;
		unique case (cmd_q)
			CMD_ADD: begin
				if (table_full) begin
					status_d = STAT_FULL;
				end else if (found_q) begin
					status_d = STAT_PRESENT;
				end else begin
					count_d   = count_q + CW'(1);
					success_d = 1'b1;
					status_d  = STAT_DONE;
				end
			end
			CMD_REMOVE: begin
				if (found_q) begin
					count_d   = count_q - CW'(1);
					success_d = 1'b1;
					status_d  = STAT_DONE;
				end
			end
			default: begin
				if (found_q) begin
					success_d = 1'b1;
					status_d  = STAT_DONE;
				end
			end
		endcase
	end

	// Memory port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rp_q[AW-1:0]];
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= s_axis_tdata[CMD_W-1:0];
			key_q <= key_norm;
		end
		if (scan_rd) pend_idx_q <= rp_q[AW-1:0];
		else if (shift_rd) pend_idx_q <= rp_q[AW-1:0] - AW'(1);
		if (cmd.finish) begin
			success_q     <= success_d;
			status_q      <= status_d;
			entry_count_q <= OUT_CNT_W'(count_d);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rp_q        <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rp_q    <= '0;
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (hit) begin
				// first match: park the pointer just past it for a removal shift
				found_q <= 1'b1;
				pend_q  <= 1'b0;
				rp_q    <= CW'(pend_idx_q) + CW'(1);
			end else if (rd_en) begin
				pend_q <= 1'b1;
				rp_q   <= rp_q + CW'(1);
			end else if (cmd.scan || cmd.shift) begin
				pend_q <= 1'b0;
			end
			if (cmd.finish) count_q <= count_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Status to controller
	always_comb begin
		stat.scan_done  = found_q || (!more && !pend_q);
		stat.need_shift = found_q && (cmd_q == CMD_REMOVE);
		stat.shift_done = !more && !pend_q;
		stat.out_free   = !out_valid_q || m_axis_tready;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {entry_count_q, status_q, success_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");
	a_count_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(count_q))
		else $error("entry count changed outside result write-back");
	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (CW'(pend_idx_q) < count_q))
		else $error("pending entry index beyond stored entries");
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten before it was taken");
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.scan || cmd.shift || cmd.finish))
		else $error("load overlaps another datapath command");
`endif

endmodule

// ===== rtl/address_blocklist_table.sv =====
// Lookup and add scan the stored entries up to the first match after the input word is taken,
// then register the result word, which is held on the output until it is taken.
// A remove that hits also shifts every entry above the match down by one before the result is
// registered; there is nothing to shift when the match is the last entry.
// Throughput: one word in flight; the scan reads one table entry per cycle from one read port.
// The next input word is taken the cycle after the result is registered, even if it waits.
// Reset: entry count and handshake state clear at once; stored keys are not cleared.
// ----------------------------------------------------------------------------
// Address blocklist table
// Ordered exact-match key table with lookup, add and remove commands.
// ----------------------------------------------------------------------------
module address_blocklist_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// command[1:0], key_high[65:2], key_low[129:66], zero pad [135:130]
	input  logic [abt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// success[0], status[2:1], entry_count[7:3]
	output logic [abt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import abt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	abt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	abt_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

// ===== tb/sv/address_blocklist_table_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Address blocklist table checker
// Watches both stream channels. Each command word taken by the table is run
// through a local model of the key table, and the predicted reply is queued.
// Each reply word is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module address_blocklist_table_check #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// command[1:0], key_high[65:2], key_low[129:66], zero pad [135:130]
	input  logic [abt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// success[0], status[2:1], entry_count[7:3]
	input  logic [abt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int unsigned                    mismatches,
	output int unsigned                    pending,
	output int unsigned                    replies_seen,
	output int unsigned                    peak_entries,
	output int unsigned                    full_rejects,
	output int unsigned                    dup_rejects,
	output int unsigned                    misses
);
	import abt_pkg::*;

	typedef struct packed {
		logic                 success;
		logic [STATUS_W-1:0]  status;
		logic [OUT_CNT_W-1:0] count;
	} table_reply_t;

	// Model of the stored keys, kept in canonical form
	logic [KEY_W-1:0] model_keys [TABLE_DEPTH];
	int unsigned      model_count;
	table_reply_t     reply_queue [$];

	// A key compares as a string: everything past the first zero byte, and
	// the last byte in any case, counts as zero.
	function automatic logic [KEY_W-1:0] canonical_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		logic             ended;
		int               i;
		k = raw;
		ended = 1'b0;
		for (i = 0; i < KEY_BYTES; i++) begin
			if (i >= KEY_CHARS || k[KEY_W-1-8*i -: 8] == 8'h00)
				ended = 1'b1;
			if (ended)
				k[KEY_W-1-8*i -: 8] = 8'h00;
		end
		return k;
	endfunction

	// Run one command against the model and return the reply it should give
	function automatic table_reply_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [KEY_W-1:0] raw);
		table_reply_t     r;
		logic [KEY_W-1:0] key;
		int unsigned      hit;
		int unsigned      i;
		key = canonical_key(raw);
		hit = model_count;
		for (i = 0; i < model_count; i++)
			if (hit == model_count && model_keys[i] == key)
				hit = i;
		r.success = 1'b0;
		r.status = STAT_ABSENT;
		case (cmd)
			CMD_ADD: begin
				// full is checked before duplicates
				if (model_count >= TABLE_DEPTH) begin
					r.status = STAT_FULL;
					full_rejects++;
				end else if (hit < model_count) begin
					r.status = STAT_PRESENT;
					dup_rejects++;
				end else begin
					model_keys[model_count] = key;
					model_count++;
					r.success = 1'b1;
					r.status = STAT_DONE;
				end
			end
			CMD_REMOVE: begin
				if (hit >= model_count) begin
					misses++;
				end else begin
					for (i = hit; i + 1 < model_count; i++)
						model_keys[i] = model_keys[i + 1];
					model_count--;
					model_keys[model_count] = '0;
					r.success = 1'b1;
					r.status = STAT_DONE;
				end
			end
			default: begin
				// lookup, and the unused code behaves the same
				if (hit < model_count) begin
					r.success = 1'b1;
					r.status = STAT_DONE;
				end else begin
					misses++;
				end
			end
		endcase
		if (model_count > peak_entries)
			peak_entries = model_count;
		r.count = model_count[OUT_CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t ns] mismatch on reply %0d: %s", $time, replies_seen, msg);
		mismatches++;
	endtask

	// Compare replies, then record new commands
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		table_reply_t got;
		if (!arst_n) begin
			model_count = 0;
			reply_queue.delete();
			mismatches = 0;
			pending = 0;
			replies_seen = 0;
			peak_entries = 0;
			full_rejects = 0;
			dup_rejects = 0;
			misses = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.success = m_axis_tdata[0];
				got.status = m_axis_tdata[2:1];
				got.count = m_axis_tdata[7:3];
				if (reply_queue.size() == 0) begin
					report_mismatch($sformatf("reply word 0x%02h with no command pending",
						m_axis_tdata));
				end else begin
					want = reply_queue.pop_front();
					if (got.success !== want.success)
						report_mismatch($sformatf("success %b, expected %b",
							got.success, want.success));
					if (got.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							got.status, want.status));
					if (got.count !== want.count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							got.count, want.count));
				end
				replies_seen++;
			end
			if (s_axis_tvalid && s_axis_tready)
				reply_queue.push_back(apply_command(s_axis_tdata[CMD_W-1:0],
					{s_axis_tdata[CMD_W +: KEY_HALF_W],
					s_axis_tdata[CMD_W+KEY_HALF_W +: KEY_HALF_W]}));
			pending = reply_queue.size();
		end
	end

endmodule

// ===== tb/sv/address_blocklist_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Address blocklist table testbench
// Drives lookup, add and remove words into the table: a directed opening that
// walks the empty, full and string-compare corners, then random traffic in
// blocks that fill, drain or mix the table. Both stream sides idle at random;
// one long reply stall backs the table up. The checker does all comparing.
// ----------------------------------------------------------------------------
module address_blocklist_table_test;
	import abt_pkg::*;

	localparam int TABLE_DEPTH   = 16;
	localparam int POOL_SIZE     = 24;
	localparam int RANDOM_BLOCKS = 13;
	localparam int BLOCK_ITEMS   = 50;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam int CYCLE_LIMIT   = 500000;

	// Unused command code; the table treats it as a lookup
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// command[1:0], key_high[65:2], key_low[129:66], zero pad [135:130]
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// success[0], status[2:1], entry_count[7:3]
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int unsigned mismatches;
	int unsigned pending_replies;
	int unsigned replies_seen;
	int unsigned peak_entries;
	int unsigned full_rejects;
	int unsigned dup_rejects;
	int unsigned misses;

	int unsigned      cycle_count;
	int unsigned      words_sent;
	int unsigned      holds_asked;
	int unsigned      holds_done;
	int unsigned      stall_left;
	int unsigned      sink_clock;
	int unsigned      sink_mode;
	logic             gaps_on;
	logic [KEY_W-1:0] pool_key [POOL_SIZE];
	int unsigned      pool_len [POOL_SIZE];
	logic [KEY_W-1:0] stray_keys [$];

	address_blocklist_table #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	address_blocklist_table_check #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.pending      (pending_replies),
		.replies_seen (replies_seen),
		.peak_entries (peak_entries),
		.full_rejects (full_rejects),
		.dup_rejects  (dup_rejects),
		.misses       (misses)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, pending_replies);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [KEY_W-1:0] random_bits();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Pool key with random bytes behind its end, which must not matter
	function automatic logic [KEY_W-1:0] emit_key(input int unsigned p);
		logic [KEY_W-1:0] k;
		int unsigned      b;
		k = pool_key[p];
		if ($urandom_range(0, 1))
			for (b = 0; b < KEY_BYTES; b++)
				if ((pool_len[p] < KEY_CHARS) ? (b > pool_len[p]) : (b == KEY_BYTES - 1))
					k[KEY_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
		return k;
	endfunction

	// Reply side: random stalls in changing moods, plus requested long holds
	initial begin
		m_axis_tready = 1'b0;
		stall_left = 0;
		sink_clock = 0;
		sink_mode = 0;
		holds_done = 0;
	end
	always @(negedge clk) begin
		sink_clock++;
		if (sink_clock % 256 == 0)
			sink_mode = $urandom_range(0, 2);
		if (holds_done != holds_asked) begin
			holds_done++;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_mode != 0 && $urandom_range(0, 99) < ((sink_mode == 1) ? 10 : 35))
				stall_left = pick_gap();
		end
	end

	// Offer one command word and hold it until taken
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] raw);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W - CMD_W - KEY_W){1'b0}}, raw[KEY_HALF_W-1:0],
			raw[KEY_W-1:KEY_HALF_W], cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// Drop valid for the requested idle time, with junk on the data lines
	task automatic idle_for(input int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {8'($urandom), random_bits()};
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic idle_maybe();
		if (gaps_on && $urandom_range(0, 99) < 35)
			idle_for(pick_gap());
	endtask

	// Stop sending until every reply is back
	task automatic wait_drained();
		idle_for(1);
		wait (pending_replies == 0);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Stimulus
	initial begin
		int unsigned      p;
		int unsigned      b;
		int unsigned      blk;
		int unsigned      n;
		int unsigned      r;
		int unsigned      len;
		traffic_mix_t     mix;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] raw;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		words_sent = 0;
		holds_asked = 0;
		gaps_on = 1'b1;

		// Key pool: empty key first, some keys that extend the one before
		for (p = 0; p < POOL_SIZE; p++) begin
			if (p >= 5 && p % 4 == 1 && pool_len[p - 1] < KEY_CHARS) begin
				pool_key[p] = pool_key[p - 1];
				pool_key[p][KEY_W-1-8*pool_len[p - 1] -: 8] = 8'($urandom_range(1, 255));
				pool_len[p] = pool_len[p - 1] + 1;
			end else begin
				len = (p == 0) ? 0 :
					(($urandom_range(0, 4) == 0) ? KEY_CHARS : $urandom_range(1, KEY_CHARS));
				pool_key[p] = '0;
				for (b = 0; b < len; b++)
					pool_key[p][KEY_W-1-8*b -: 8] = 8'($urandom_range(1, 255));
				pool_len[p] = len;
			end
		end

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, empty key, truncation, spare code
		send_command(CMD_LOOKUP, '0);
		idle_maybe();
		send_command(CMD_REMOVE, '1);
		send_command(CMD_ADD, '0);
		raw = random_bits();
		raw[KEY_W-1 -: 8] = 8'h00;
		send_command(CMD_ADD, raw);
		idle_maybe();
		send_command(CMD_LOOKUP, '1);
		send_command(CMD_ADD, '1);
		send_command(CMD_LOOKUP, {{(KEY_W - 8){1'b1}}, 8'h00});
		send_command(CMD_SPARE, {{(KEY_W - 8){1'b1}}, 8'h5A});
		idle_maybe();
		send_command(CMD_REMOVE, '0);
		send_command(CMD_LOOKUP, '0);

		// Directed: fill to the limit, then full wins over duplicate
		for (p = 1; p <= TABLE_DEPTH - 1; p++) begin
			send_command(CMD_ADD, emit_key(p));
			idle_maybe();
		end
		send_command(CMD_ADD, emit_key(TABLE_DEPTH));
		send_command(CMD_ADD, '1);

		// Directed: remove from the middle, the end and the front
		send_command(CMD_REMOVE, emit_key(8));
		send_command(CMD_REMOVE, emit_key(TABLE_DEPTH - 1));
		idle_maybe();
		send_command(CMD_REMOVE, '1);
		wait_drained();

		// Random traffic in blocks with a chosen mix
		for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk == 4 || blk == 9)
				wait_drained();
			mix = traffic_mix_t'($urandom_range(0, 2));
			// block 2 keeps offering words back to back under a long reply hold
			gaps_on = (blk == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			for (n = 0; n < BLOCK_ITEMS; n++) begin
				if (blk == 2 && n == 10)
					holds_asked++;
				r = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:
						cmd = (r < 65) ? CMD_ADD : (r < 80) ? CMD_REMOVE :
							(r < 95) ? CMD_LOOKUP : CMD_SPARE;
					MIX_DRAIN:
						cmd = (r < 15) ? CMD_ADD : (r < 75) ? CMD_REMOVE :
							(r < 95) ? CMD_LOOKUP : CMD_SPARE;
					default:
						cmd = (r < 30) ? CMD_ADD : (r < 60) ? CMD_REMOVE :
							(r < 95) ? CMD_LOOKUP : CMD_SPARE;
				endcase
				// random keys sent with an add are fed back to drain blocks
				if (cmd == CMD_REMOVE && mix == MIX_DRAIN && stray_keys.size() > 0 &&
						$urandom_range(0, 3) == 0) begin
					raw = stray_keys.pop_front();
				end else if ($urandom_range(0, 99) < 8) begin
					raw = random_bits();
					if (cmd == CMD_ADD)
						stray_keys.push_back(raw);
				end else begin
					raw = emit_key($urandom_range(0, POOL_SIZE - 1));
				end
				send_command(cmd, raw);
				idle_maybe();
			end
		end

		// Drain and report
		idle_for(1);
		wait (pending_replies == 0);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Ran %0d commands and checked %0d replies; the table peaked at %0d entries.",
			words_sent, replies_seen, peak_entries);
		$display("Rejected %0d adds as full and %0d as duplicates; %0d lookups or removes missed.",
			full_rejects, dup_rejects, misses);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
